// ----- rtl/core/rmd160_pkg.sv -----
package rmd160_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenFill = 6'd56;

  // message word select, left line
  function automatic logic [3:0] sel_l(input logic [6:0] j);
    logic [3:0] r;
    case (j)
      7'd0: r = 4'd0;   7'd1: r = 4'd1;   7'd2: r = 4'd2;   7'd3: r = 4'd3;
      7'd4: r = 4'd4;   7'd5: r = 4'd5;   7'd6: r = 4'd6;   7'd7: r = 4'd7;
      7'd8: r = 4'd8;   7'd9: r = 4'd9;   7'd10: r = 4'd10; 7'd11: r = 4'd11;
      7'd12: r = 4'd12; 7'd13: r = 4'd13; 7'd14: r = 4'd14; 7'd15: r = 4'd15;
      7'd16: r = 4'd7;  7'd17: r = 4'd4;  7'd18: r = 4'd13; 7'd19: r = 4'd1;
      7'd20: r = 4'd10; 7'd21: r = 4'd6;  7'd22: r = 4'd15; 7'd23: r = 4'd3;
      7'd24: r = 4'd12; 7'd25: r = 4'd0;  7'd26: r = 4'd9;  7'd27: r = 4'd5;
      7'd28: r = 4'd2;  7'd29: r = 4'd14; 7'd30: r = 4'd11; 7'd31: r = 4'd8;
      7'd32: r = 4'd3;  7'd33: r = 4'd10; 7'd34: r = 4'd14; 7'd35: r = 4'd4;
      7'd36: r = 4'd9;  7'd37: r = 4'd15; 7'd38: r = 4'd8;  7'd39: r = 4'd1;
      7'd40: r = 4'd2;  7'd41: r = 4'd7;  7'd42: r = 4'd0;  7'd43: r = 4'd6;
      7'd44: r = 4'd13; 7'd45: r = 4'd11; 7'd46: r = 4'd5;  7'd47: r = 4'd12;
      7'd48: r = 4'd1;  7'd49: r = 4'd9;  7'd50: r = 4'd11; 7'd51: r = 4'd10;
      7'd52: r = 4'd0;  7'd53: r = 4'd8;  7'd54: r = 4'd12; 7'd55: r = 4'd4;
      7'd56: r = 4'd13; 7'd57: r = 4'd3;  7'd58: r = 4'd7;  7'd59: r = 4'd15;
      7'd60: r = 4'd14; 7'd61: r = 4'd5;  7'd62: r = 4'd6;  7'd63: r = 4'd2;
      7'd64: r = 4'd4;  7'd65: r = 4'd0;  7'd66: r = 4'd5;  7'd67: r = 4'd9;
      7'd68: r = 4'd7;  7'd69: r = 4'd12; 7'd70: r = 4'd2;  7'd71: r = 4'd10;
      7'd72: r = 4'd14; 7'd73: r = 4'd1;  7'd74: r = 4'd3;  7'd75: r = 4'd8;
      7'd76: r = 4'd11; 7'd77: r = 4'd6;  7'd78: r = 4'd15; 7'd79: r = 4'd13;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // message word select, right line
  function automatic logic [3:0] sel_r(input logic [6:0] j);
    logic [3:0] r;
    case (j)
      7'd0: r = 4'd5;   7'd1: r = 4'd14;  7'd2: r = 4'd7;   7'd3: r = 4'd0;
      7'd4: r = 4'd9;   7'd5: r = 4'd2;   7'd6: r = 4'd11;  7'd7: r = 4'd4;
      7'd8: r = 4'd13;  7'd9: r = 4'd6;   7'd10: r = 4'd15; 7'd11: r = 4'd8;
      7'd12: r = 4'd1;  7'd13: r = 4'd10; 7'd14: r = 4'd3;  7'd15: r = 4'd12;
      7'd16: r = 4'd6;  7'd17: r = 4'd11; 7'd18: r = 4'd3;  7'd19: r = 4'd7;
      7'd20: r = 4'd0;  7'd21: r = 4'd13; 7'd22: r = 4'd5;  7'd23: r = 4'd10;
      7'd24: r = 4'd14; 7'd25: r = 4'd15; 7'd26: r = 4'd8;  7'd27: r = 4'd12;
      7'd28: r = 4'd4;  7'd29: r = 4'd9;  7'd30: r = 4'd1;  7'd31: r = 4'd2;
      7'd32: r = 4'd15; 7'd33: r = 4'd5;  7'd34: r = 4'd1;  7'd35: r = 4'd3;
      7'd36: r = 4'd7;  7'd37: r = 4'd14; 7'd38: r = 4'd6;  7'd39: r = 4'd9;
      7'd40: r = 4'd11; 7'd41: r = 4'd8;  7'd42: r = 4'd12; 7'd43: r = 4'd2;
      7'd44: r = 4'd10; 7'd45: r = 4'd0;  7'd46: r = 4'd4;  7'd47: r = 4'd13;
      7'd48: r = 4'd8;  7'd49: r = 4'd6;  7'd50: r = 4'd4;  7'd51: r = 4'd1;
      7'd52: r = 4'd3;  7'd53: r = 4'd11; 7'd54: r = 4'd15; 7'd55: r = 4'd0;
      7'd56: r = 4'd5;  7'd57: r = 4'd12; 7'd58: r = 4'd2;  7'd59: r = 4'd13;
      7'd60: r = 4'd9;  7'd61: r = 4'd7;  7'd62: r = 4'd10; 7'd63: r = 4'd14;
      7'd64: r = 4'd12; 7'd65: r = 4'd15; 7'd66: r = 4'd10; 7'd67: r = 4'd4;
      7'd68: r = 4'd1;  7'd69: r = 4'd5;  7'd70: r = 4'd8;  7'd71: r = 4'd7;
      7'd72: r = 4'd6;  7'd73: r = 4'd2;  7'd74: r = 4'd13; 7'd75: r = 4'd14;
      7'd76: r = 4'd0;  7'd77: r = 4'd3;  7'd78: r = 4'd9;  7'd79: r = 4'd11;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // rotate amount, left line
  function automatic logic [3:0] rot_l(input logic [6:0] j);
    logic [3:0] r;
    case (j)
      7'd0: r = 4'd11;  7'd1: r = 4'd14;  7'd2: r = 4'd15;  7'd3: r = 4'd12;
      7'd4: r = 4'd5;   7'd5: r = 4'd8;   7'd6: r = 4'd7;   7'd7: r = 4'd9;
      7'd8: r = 4'd11;  7'd9: r = 4'd13;  7'd10: r = 4'd14; 7'd11: r = 4'd15;
      7'd12: r = 4'd6;  7'd13: r = 4'd7;  7'd14: r = 4'd9;  7'd15: r = 4'd8;
      7'd16: r = 4'd7;  7'd17: r = 4'd6;  7'd18: r = 4'd8;  7'd19: r = 4'd13;
      7'd20: r = 4'd11; 7'd21: r = 4'd9;  7'd22: r = 4'd7;  7'd23: r = 4'd15;
      7'd24: r = 4'd7;  7'd25: r = 4'd12; 7'd26: r = 4'd15; 7'd27: r = 4'd9;
      7'd28: r = 4'd11; 7'd29: r = 4'd7;  7'd30: r = 4'd13; 7'd31: r = 4'd12;
      7'd32: r = 4'd11; 7'd33: r = 4'd13; 7'd34: r = 4'd6;  7'd35: r = 4'd7;
      7'd36: r = 4'd14; 7'd37: r = 4'd9;  7'd38: r = 4'd13; 7'd39: r = 4'd15;
      7'd40: r = 4'd14; 7'd41: r = 4'd8;  7'd42: r = 4'd13; 7'd43: r = 4'd6;
      7'd44: r = 4'd5;  7'd45: r = 4'd12; 7'd46: r = 4'd7;  7'd47: r = 4'd5;
      7'd48: r = 4'd11; 7'd49: r = 4'd12; 7'd50: r = 4'd14; 7'd51: r = 4'd15;
      7'd52: r = 4'd14; 7'd53: r = 4'd15; 7'd54: r = 4'd9;  7'd55: r = 4'd8;
      7'd56: r = 4'd9;  7'd57: r = 4'd14; 7'd58: r = 4'd5;  7'd59: r = 4'd6;
      7'd60: r = 4'd8;  7'd61: r = 4'd6;  7'd62: r = 4'd5;  7'd63: r = 4'd12;
      7'd64: r = 4'd9;  7'd65: r = 4'd15; 7'd66: r = 4'd5;  7'd67: r = 4'd11;
      7'd68: r = 4'd6;  7'd69: r = 4'd8;  7'd70: r = 4'd13; 7'd71: r = 4'd12;
      7'd72: r = 4'd5;  7'd73: r = 4'd12; 7'd74: r = 4'd13; 7'd75: r = 4'd14;
      7'd76: r = 4'd11; 7'd77: r = 4'd8;  7'd78: r = 4'd5;  7'd79: r = 4'd6;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // rotate amount, right line
  function automatic logic [3:0] rot_r(input logic [6:0] j);
    logic [3:0] r;
    case (j)
      7'd0: r = 4'd8;   7'd1: r = 4'd9;   7'd2: r = 4'd9;   7'd3: r = 4'd11;
      7'd4: r = 4'd13;  7'd5: r = 4'd15;  7'd6: r = 4'd15;  7'd7: r = 4'd5;
      7'd8: r = 4'd7;   7'd9: r = 4'd7;   7'd10: r = 4'd8;  7'd11: r = 4'd11;
      7'd12: r = 4'd14; 7'd13: r = 4'd14; 7'd14: r = 4'd12; 7'd15: r = 4'd6;
      7'd16: r = 4'd9;  7'd17: r = 4'd13; 7'd18: r = 4'd15; 7'd19: r = 4'd7;
      7'd20: r = 4'd12; 7'd21: r = 4'd8;  7'd22: r = 4'd9;  7'd23: r = 4'd11;
      7'd24: r = 4'd7;  7'd25: r = 4'd7;  7'd26: r = 4'd12; 7'd27: r = 4'd7;
      7'd28: r = 4'd6;  7'd29: r = 4'd15; 7'd30: r = 4'd13; 7'd31: r = 4'd11;
      7'd32: r = 4'd9;  7'd33: r = 4'd7;  7'd34: r = 4'd15; 7'd35: r = 4'd11;
      7'd36: r = 4'd8;  7'd37: r = 4'd6;  7'd38: r = 4'd6;  7'd39: r = 4'd14;
      7'd40: r = 4'd12; 7'd41: r = 4'd13; 7'd42: r = 4'd5;  7'd43: r = 4'd14;
      7'd44: r = 4'd13; 7'd45: r = 4'd13; 7'd46: r = 4'd7;  7'd47: r = 4'd5;
      7'd48: r = 4'd15; 7'd49: r = 4'd5;  7'd50: r = 4'd8;  7'd51: r = 4'd11;
      7'd52: r = 4'd14; 7'd53: r = 4'd14; 7'd54: r = 4'd6;  7'd55: r = 4'd14;
      7'd56: r = 4'd6;  7'd57: r = 4'd9;  7'd58: r = 4'd12; 7'd59: r = 4'd9;
      7'd60: r = 4'd12; 7'd61: r = 4'd5;  7'd62: r = 4'd15; 7'd63: r = 4'd8;
      7'd64: r = 4'd8;  7'd65: r = 4'd5;  7'd66: r = 4'd12; 7'd67: r = 4'd9;
      7'd68: r = 4'd12; 7'd69: r = 4'd5;  7'd70: r = 4'd14; 7'd71: r = 4'd6;
      7'd72: r = 4'd8;  7'd73: r = 4'd13; 7'd74: r = 4'd6;  7'd75: r = 4'd5;
      7'd76: r = 4'd15; 7'd77: r = 4'd13; 7'd78: r = 4'd11; 7'd79: r = 4'd11;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] add_l(input logic [2:0] g);
    logic [31:0] r;
    case (g)
      3'd0: r = 32'h00000000;
      3'd1: r = 32'h5a827999;
      3'd2: r = 32'h6ed9eba1;
      3'd3: r = 32'h8f1bbcdc;
      3'd4: r = 32'ha953fd4e;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] add_r(input logic [2:0] g);
    logic [31:0] r;
    case (g)
      3'd0: r = 32'h50a28be6;
      3'd1: r = 32'h5c4dd124;
      3'd2: r = 32'h6d703ef3;
      3'd3: r = 32'h7a6d76e9;
      3'd4: r = 32'h00000000;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] boolfn(input logic [2:0] g, input logic [31:0] x,
                                         input logic [31:0] y, input logic [31:0] z);
    logic [31:0] r;
    case (g)
      3'd0: r = x ^ y ^ z;
      3'd1: r = (x & y) | (~x & z);
      3'd2: r = (x | ~y) ^ z;
      3'd3: r = (x & z) | (y & ~z);
      default: r = x ^ (y | ~z);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] d;
    d = {v, v} << s;
    return d[63:32];
  endfunction

endpackage

// ----- rtl/core/ripemd160_stream_hasher_core.sv -----
// a byte that fills no block stalls the input while its word is read (S_BRD) and merged back (S_BWR)
// a full block adds read setup, 80 rounds at one per cycle, and the chaining update
// end of message: padding bytes are merged like data, two length words are written, blocks are hashed, then 5 words
// one request at a time: in_stall is high whenever the core is not idle
// reset: synchronous active-low rst_n loads the initial chaining words and clears counts
module ripemd160_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_BRD   = 8'b00000010,  // read word for byte merge
    S_BWR   = 8'b00000100,  // merge and write back
    S_RRD   = 8'b00001000,  // issue round reads
    S_RND   = 8'b00010000,  // perform one round
    S_FIN   = 8'b00100000,  // chaining update
    S_LEN   = 8'b01000000,  // write length words
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r;

  // message block memory, two read ports
  logic [31:0] mem [16];
  logic [31:0] rd_l_r, rd_r_r;
  logic [3:0]  ra_l, ra_r, wa;
  logic [31:0] wd;
  logic        we;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_l_r <= mem[ra_l];
    rd_r_r <= mem[ra_r];
  end

  logic [31:0] h_r [5];
  logic [31:0] al_r, bl_r, cl_r, dl_r, el_r, ar_r, br_r, cr_r, dr_r, er_r;
  logic [6:0]  rnd_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [63:0] len_r;
  logic        pad_r;     // in padding phase
  logic        padded_r;  // 0x80 already placed
  logic        last_r;    // current compression is the final one
  logic        lenw_r;    // second length word pending
  logic [7:0]  byte_r;
  logic [2:0]  onum_r;

  // round datapath
  logic [2:0]  grp_l, grp_r;
  logic [31:0] tl, tr;
  assign grp_l = rnd_r[6:4];
  assign grp_r = 3'd4 - rnd_r[6:4];
  assign tl = rmd160_pkg::rotl(al_r + rmd160_pkg::boolfn(grp_l, bl_r, cl_r, dl_r) + rd_l_r
              + rmd160_pkg::add_l(grp_l), {1'b0, rmd160_pkg::rot_l(rnd_r)}) + el_r;
  assign tr = rmd160_pkg::rotl(ar_r + rmd160_pkg::boolfn(grp_r, br_r, cr_r, dr_r) + rd_r_r
              + rmd160_pkg::add_r(grp_l), {1'b0, rmd160_pkg::rot_r(rnd_r)}) + er_r;

  // byte merge into read word
  logic [31:0] merged;
  always_comb begin
    merged = rd_l_r;
    case (fill_r[1:0])
      2'd0: merged = {24'd0, byte_r};
      2'd1: merged[15:8] = byte_r;
      2'd2: merged[23:16] = byte_r;
      default: merged[31:24] = byte_r;
    endcase
  end

  // read one round ahead while rounds run
  logic [6:0] rd_rnd;
  assign rd_rnd = (state_r == S_RND) ? rnd_r + 7'd1 : rnd_r;

  // memory port control
  always_comb begin
    ra_l = rmd160_pkg::sel_l(rd_rnd);
    ra_r = rmd160_pkg::sel_r(rd_rnd);
    if (state_r == S_BRD) ra_l = fill_r[5:2];
    we = 1'b0;
    wa = fill_r[5:2];
    wd = merged;
    if (state_r == S_BWR) we = 1'b1;
    if (state_r == S_LEN) begin
      we = 1'b1;
      wa = lenw_r ? 4'd15 : 4'd14;
      wd = lenw_r ? len_r[63:32] : len_r[31:0];
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_digest_word = h_r[onum_r];
  assign out_word_number = onum_r;
  assign out_last_word = (onum_r == 3'd4);

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r <= '0;
      bits_r <= '0;
      pad_r <= 1'b0;
      padded_r <= 1'b0;
      last_r <= 1'b0;
      lenw_r <= 1'b0;
      onum_r <= '0;
      rnd_r <= '0;
      h_r[0] <= rmd160_pkg::H0; h_r[1] <= rmd160_pkg::H1; h_r[2] <= rmd160_pkg::H2;
      h_r[3] <= rmd160_pkg::H3; h_r[4] <= rmd160_pkg::H4;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            len_r <= bits_r + (in_byte_present ? 64'd8 : 64'd0);
            pad_r <= in_end_of_message;
            padded_r <= 1'b0;
            if (in_byte_present) begin
              bits_r <= bits_r + 64'd8;
              byte_r <= in_byte_value;
              state_r <= S_BRD;
            end else if (in_end_of_message) begin
              byte_r <= rmd160_pkg::PadByte;
              padded_r <= 1'b1;
              state_r <= S_BRD;
            end
          end
        end
        S_BRD: state_r <= S_BWR;
        S_BWR: begin
          fill_r <= fill_r + 6'd1;
          rnd_r <= '0;
          if (fill_r == 6'd63) begin
            last_r <= 1'b0;
            state_r <= S_RRD;
          end else if (pad_r && padded_r && (fill_r + 6'd1) == rmd160_pkg::LenFill) begin
            lenw_r <= 1'b0;
            state_r <= S_LEN;
          end else if (pad_r) begin
            byte_r <= padded_r ? 8'd0 : rmd160_pkg::PadByte;
            padded_r <= 1'b1;
            state_r <= S_BRD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_LEN: begin
          lenw_r <= 1'b1;
          if (lenw_r) begin
            last_r <= 1'b1;
            rnd_r <= '0;
            state_r <= S_RRD;
          end
        end
        S_RRD: begin
          al_r <= h_r[0]; bl_r <= h_r[1]; cl_r <= h_r[2]; dl_r <= h_r[3]; el_r <= h_r[4];
          ar_r <= h_r[0]; br_r <= h_r[1]; cr_r <= h_r[2]; dr_r <= h_r[3]; er_r <= h_r[4];
          state_r <= S_RND;
        end
        S_RND: begin
          al_r <= el_r; el_r <= dl_r; dl_r <= rmd160_pkg::rotl(cl_r, 5'd10);
          cl_r <= bl_r; bl_r <= tl;
          ar_r <= er_r; er_r <= dr_r; dr_r <= rmd160_pkg::rotl(cr_r, 5'd10);
          cr_r <= br_r; br_r <= tr;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'd79) state_r <= S_FIN;
        end
        S_FIN: begin
          h_r[1] <= h_r[2] + dl_r + er_r;
          h_r[2] <= h_r[3] + el_r + ar_r;
          h_r[3] <= h_r[4] + al_r + br_r;
          h_r[4] <= h_r[0] + bl_r + cr_r;
          h_r[0] <= h_r[1] + cl_r + dr_r;
          fill_r <= '0;
          rnd_r <= '0;
          onum_r <= '0;
          if (last_r) begin
            state_r <= S_OUT;
          end else if (pad_r) begin
            // block filled during padding, keep going
            if (padded_r && rmd160_pkg::LenFill == 6'd0) state_r <= S_LEN;
            else begin
              byte_r <= padded_r ? 8'd0 : rmd160_pkg::PadByte;
              padded_r <= 1'b1;
              state_r <= S_BRD;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            onum_r <= onum_r + 3'd1;
            if (onum_r == 3'd4) begin
              state_r <= S_IDLE;
              bits_r <= '0;
              fill_r <= '0;
              h_r[0] <= rmd160_pkg::H0; h_r[1] <= rmd160_pkg::H1;
              h_r[2] <= rmd160_pkg::H2; h_r[3] <= rmd160_pkg::H3;
              h_r[4] <= rmd160_pkg::H4;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
